@@ rtl/core/x86sr_pkg.sv @@
// Package: command codes, flag bundle and operand size constants of the shift/rotate/logic ALU.
package x86sr_pkg;

	localparam int unsigned WORD_TOP_POS = 15;
	localparam int unsigned BYTE_TOP_POS = 7;

	// Largest shift amount that still matters for a linear shift of a 16-bit operand
	localparam logic [4:0] SHIFT_CLAMP = 5'd17;

	typedef enum logic [3:0] {
		CMD_ROL  = 4'd0,
		CMD_ROR  = 4'd1,
		CMD_RCL  = 4'd2,
		CMD_RCR  = 4'd3,
		CMD_SHL  = 4'd4,
		CMD_SHR  = 4'd5,
		CMD_SAR  = 4'd6,
		CMD_AND  = 4'd7,
		CMD_OR   = 4'd8,
		CMD_XOR  = 4'd9,
		CMD_TEST = 4'd10
	} cmd_t;

	typedef struct packed {
		logic c;
		logic o;
		logic z;
		logic s;
	} flags_t;

endpackage

@@ rtl/core/x86sr_in_if.sv @@
// Interface: operation request channel of the shift/rotate/logic ALU.
interface x86sr_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic        word_size;
	logic [15:0] dest_value;
	logic [15:0] source_value;
	logic [7:0]  shift_count;

	modport source (output valid, command, word_size, dest_value, source_value, shift_count,
		input ready);
	modport sink (input valid, command, word_size, dest_value, source_value, shift_count,
		output ready);
endinterface

@@ rtl/core/x86sr_out_if.sv @@
// Interface: result channel of the shift/rotate/logic ALU.
interface x86sr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_value;
	logic        write_back;
	logic        carry_out;
	logic        overflow_out;
	logic        zero_out;
	logic        sign_out;

	modport source (output valid, result_value, write_back, carry_out, overflow_out,
		zero_out, sign_out, input ready);
	modport sink (input valid, result_value, write_back, carry_out, overflow_out,
		zero_out, sign_out, output ready);
endinterface

@@ rtl/core/x86sr_exec.sv @@
// Combinational execute stage: barrel shifts, rotates, logic ops and flag update.
module x86sr_exec
	import x86sr_pkg::*;
(
	input  logic [3:0]  command,
	input  logic        word_size,
	input  logic [15:0] dest_value,
	input  logic [15:0] source_value,
	input  logic [7:0]  shift_count,
	input  flags_t      flags_in,
	output logic [15:0] result_value,
	output logic        write_back,
	output flags_t      flags_out
);

	// count mod 17: 16 == -1 (mod 17)
	function automatic logic [4:0] mod17(input logic [7:0] n);
		logic signed [5:0] d;
		d = $signed({2'b00, n[3:0]}) - $signed({2'b00, n[7:4]});
		if (d < 0)
			d = d + 6'sd17;
		return d[4:0];
	endfunction

	// count mod 9: 8 == -1 (mod 9), applied twice
	function automatic logic [3:0] mod9(input logic [7:0] n);
		logic signed [5:0] d;
		d = $signed({3'b000, n[2:0]}) - $signed({3'b000, n[5:3]}) + $signed({4'b0000, n[7:6]});
		if (d < 0)
			d = d + 6'sd9;
		else if (d >= 6'sd9)
			d = d - 6'sd9;
		return d[3:0];
	endfunction

	logic [15:0] mask, v, s;
	logic [4:0]  nc;
	logic        top_v;

	assign mask  = word_size ? 16'hFFFF : 16'h00FF;
	assign v     = dest_value & mask;
	assign s     = source_value & mask;
	assign nc    = (shift_count > {3'b000, SHIFT_CLAMP}) ? SHIFT_CLAMP : shift_count[4:0];
	assign top_v = word_size ? v[WORD_TOP_POS] : v[BYTE_TOP_POS];

	// linear shifts
	logic [32:0]        shl_p;
	logic [16:0]        shr_p;
	logic signed [16:0] sar_x;
	logic signed [17:0] sar_p;

	assign shl_p = {17'b0, v} << nc;
	assign shr_p = {v, 1'b0} >> nc;
	assign sar_x = word_size ? {v[15], v} : {{9{v[7]}}, v[7:0]};
	assign sar_p = $signed({sar_x, 1'b0}) >>> nc;

	// plain rotates through a doubled operand
	logic [31:0] rol16_w, ror16_w;
	logic [15:0] rol8_w, ror8_w;

	assign rol16_w = {v, v} << shift_count[3:0];
	assign ror16_w = {v, v} >> shift_count[3:0];
	assign rol8_w  = {v[7:0], v[7:0]} << shift_count[2:0];
	assign ror8_w  = {v[7:0], v[7:0]} >> shift_count[2:0];

	// rotates through carry: 17- or 9-bit ring
	logic [16:0] u17;
	logic [8:0]  u9;
	logic [4:0]  k17;
	logic [3:0]  k9;
	logic [33:0] rcl17_w, rcr17_w;
	logic [17:0] rcl9_w, rcr9_w;

	assign u17     = {flags_in.c, v};
	assign u9      = {flags_in.c, v[7:0]};
	assign k17     = mod17(shift_count);
	assign k9      = mod9(shift_count);
	assign rcl17_w = {u17, u17} << k17;
	assign rcr17_w = {u17, u17} >> k17;
	assign rcl9_w  = {u9, u9} << k9;
	assign rcr9_w  = {u9, u9} >> k9;

	logic [15:0] r;
	logic        c_new;
	logic        top_r, sub_r;

	always_comb begin
		r     = v;
		c_new = flags_in.c;
		unique case (cmd_t'(command))
			CMD_ROL: r = word_size ? rol16_w[31:16] : {8'b0, rol8_w[15:8]};
			CMD_ROR: r = word_size ? ror16_w[15:0] : {8'b0, ror8_w[7:0]};
			CMD_RCL: begin
				r     = word_size ? rcl17_w[32:17] : {8'b0, rcl9_w[16:9]};
				c_new = word_size ? rcl17_w[33] : rcl9_w[17];
			end
			CMD_RCR: begin
				r     = word_size ? rcr17_w[15:0] : {8'b0, rcr9_w[7:0]};
				c_new = word_size ? rcr17_w[16] : rcr9_w[8];
			end
			CMD_SHL: begin
				r     = shl_p[15:0] & mask;
				c_new = word_size ? shl_p[16] : shl_p[8];
			end
			CMD_SHR: begin
				r     = shr_p[16:1];
				c_new = shr_p[0];
			end
			CMD_SAR: begin
				r     = sar_p[16:1] & mask;
				c_new = sar_p[0];
			end
			CMD_AND, CMD_TEST: r = v & s;
			CMD_OR:            r = v | s;
			CMD_XOR:           r = v ^ s;
			default:           r = v;
		endcase
	end

	assign top_r = word_size ? r[WORD_TOP_POS] : r[BYTE_TOP_POS];
	assign sub_r = word_size ? r[WORD_TOP_POS - 1] : r[BYTE_TOP_POS - 1];

	always_comb begin
		result_value = r;
		write_back   = 1'b1;
		flags_out    = flags_in;
		unique case (cmd_t'(command))
			CMD_ROL, CMD_ROR, CMD_RCL, CMD_RCR, CMD_SHL, CMD_SHR, CMD_SAR: begin
				if (shift_count == 8'd0) begin
					result_value = v;
				end else begin
					flags_out.c = (command == CMD_ROL) ? r[0] :
						(command == CMD_ROR) ? top_r : c_new;
					case (cmd_t'(command))
						CMD_ROL, CMD_RCL, CMD_SHL: flags_out.o = top_r ^ flags_out.c;
						CMD_ROR, CMD_RCR:          flags_out.o = top_r ^ sub_r;
						CMD_SHR:                   flags_out.o = (shift_count == 8'd1) & top_v;
						default:                   flags_out.o = 1'b0;
					endcase
					if (command >= CMD_SHL) begin
						flags_out.z = (r == 16'd0);
						flags_out.s = top_r;
					end
				end
			end
			CMD_AND, CMD_OR, CMD_XOR, CMD_TEST: begin
				write_back  = (command != CMD_TEST);
				flags_out.c = 1'b0;
				flags_out.o = 1'b0;
				flags_out.z = (r == 16'd0);
				flags_out.s = top_r;
			end
			default: begin
				result_value = v;
				write_back   = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/core/x86_shift_rotate_logic_alu.sv @@
// Top level: registered shift/rotate/logic ALU with kept carry, overflow, zero and sign flags.
// Pipeline: a word passes the input register, then the result register, to the result channel.
// Throughput: one word per cycle while the result side is not stalled; the execute stage is
//   parallel combinational shift, rotate and logic paths plus flag logic.
// Reset (arst_n low, asynchronous): both stages empty, all four flags cleared to 0.
module x86_shift_rotate_logic_alu
	import x86sr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	x86sr_in_if.sink   req,
	x86sr_out_if.source rsp
);

	// input register stage
	logic        valid_s1;
	logic [3:0]  command_s1;
	logic        word_size_s1;
	logic [15:0] dest_s1;
	logic [15:0] source_s1;
	logic [7:0]  count_s1;

	// result register and the architectural flags
	logic        rsp_valid_q;
	logic [15:0] result_q;
	logic        write_back_q;
	flags_t      flags_q;

	logic [15:0] exec_result;
	logic        exec_write_back;
	flags_t      exec_flags;
	logic        advance;

	// Stage 1 moves into the result register whenever that slot is free or being drained.
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			command_s1   <= req.command;
			word_size_s1 <= req.word_size;
			dest_s1      <= req.dest_value;
			source_s1    <= req.source_value;
			count_s1     <= req.shift_count;
		end
	end

	// Flags are read here and written back at the same edge the result loads, so a
	// dependent word right behind (RCL/RCR, kept flags) sees the updated state.
	x86sr_exec u_exec (
		.command      (command_s1),
		.word_size    (word_size_s1),
		.dest_value   (dest_s1),
		.source_value (source_s1),
		.shift_count  (count_s1),
		.flags_in     (flags_q),
		.result_value (exec_result),
		.write_back   (exec_write_back),
		.flags_out    (exec_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			flags_q     <= '0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1)
				flags_q <= exec_flags;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q     <= exec_result;
			write_back_q <= exec_write_back;
		end
	end

	// The flags register only changes when the result register loads, so it doubles
	// as the flag fields of the shown result.
	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = result_q;
	assign rsp.write_back   = write_back_q;
	assign rsp.carry_out    = flags_q.c;
	assign rsp.overflow_out = flags_q.o;
	assign rsp.zero_out     = flags_q.z;
	assign rsp.sign_out     = flags_q.s;

endmodule

@@ rtl/core/x86sr_checker.sv @@
// Checker: port-level assertions for the shift/rotate/logic ALU, bound to its top level.
module x86sr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] rsp_result_value,
	input logic        rsp_write_back,
	input logic        rsp_carry_out,
	input logic        rsp_overflow_out,
	input logic        rsp_zero_out,
	input logic        rsp_sign_out
);

	a_rsp_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result valid dropped while stalled");

	a_rsp_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_write_back)
			&& $stable(rsp_carry_out) && $stable(rsp_overflow_out)
			&& $stable(rsp_zero_out) && $stable(rsp_sign_out))
		else $error("result word changed while stalled");

	// Input only back-pressures when a full result is held by the consumer.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled without a stalled result");

	// Every accepted word must be followed by a valid result on the result channel.
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("accepted word did not reach the result register");

endmodule

bind x86_shift_rotate_logic_alu x86sr_checker u_x86sr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_result_value (rsp.result_value),
	.rsp_write_back   (rsp.write_back),
	.rsp_carry_out    (rsp.carry_out),
	.rsp_overflow_out (rsp.overflow_out),
	.rsp_zero_out     (rsp.zero_out),
	.rsp_sign_out     (rsp.sign_out)
);

@@ tb/x86_shift_rotate_logic_alu_test.sv @@
// Self-checking testbench for the shift/rotate/logic ALU: corners, random traffic, stalls.
module x86_shift_rotate_logic_alu_test
	import x86sr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Codes past TEST are not operations; the block passes the operand through.
	localparam logic [3:0] CMD_UNUSED_LO = CMD_TEST + 4'd1;
	localparam logic [3:0] CMD_CODE_MAX  = 4'hF;

	// Two register stages, so this short drain is plenty after the last word.
	localparam int unsigned DRAIN_CYCLES = 8;
	// Worst case is far below this: ~1700 words plus one long receiver hold-off.
	localparam int unsigned CYCLE_LIMIT = 500000;
	// Length of the long receiver hold-off.
	localparam int unsigned HOLD_OFF_CYCLES = 120;

	// One result word as the block should present it.
	typedef struct {
		logic [15:0] result_value;
		logic        write_back;
		flags_t      flags;
	} alu_word_t;

	logic clk;
	logic arst_n;

	x86sr_in_if  req();
	x86sr_out_if rsp();

	x86_shift_rotate_logic_alu dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Flag state held across words, mirrors the block after reset.
	flags_t kept_flags = '0;

	// Results computed at input acceptance, consumed in order on the result side.
	alu_word_t pending_results[$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// Idle controls, percent of cycles; changed per phase by the test tasks.
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	// Long receiver hold-off: started by a test task, timed by its own process.
	event hold_off_start;
	logic hold_off_active;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Runaway guard: the run should never get near this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Hold-off counter: keeps the receiver off while a hold-off runs.
	initial begin : hold_off_counter
		hold_off_active = 1'b0;
		forever begin
			@(hold_off_start);
			hold_off_active <= 1'b1;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
			hold_off_active <= 1'b0;
		end
	end

	// Next-state of the ALU for one accepted word; updates kept_flags.
	function automatic alu_word_t compute_alu_word(input logic [3:0] cmd, input logic wide,
		input logic [15:0] dest, input logic [15:0] src, input logic [7:0] count);
		logic [15:0] mask;
		logic [15:0] top;
		logic [15:0] sub;
		logic [15:0] v;
		logic [15:0] s;
		int unsigned pos;
		logic c;
		logic o;
		logic msb;
		logic lsb;
		alu_word_t res;
		mask = wide ? 16'hFFFF : 16'h00FF;
		pos  = wide ? WORD_TOP_POS : BYTE_TOP_POS;
		top  = 16'd1 << pos;
		sub  = top >> 1;
		v    = dest & mask;
		s    = src & mask;
		c    = kept_flags.c;
		o    = kept_flags.o;
		res.write_back = 1'b1;
		if (cmd <= CMD_SAR) begin
			// Zero count: operand and all flags untouched.
			if (count != 8'd0) begin
				for (int i = 0; i < count; i++) begin
					msb = v[pos];
					lsb = v[0];
					case (cmd)
						CMD_ROL: begin
							c = msb;
							v = ((v << 1) | c) & mask;
							o = v[pos] ^ c;
						end
						CMD_ROR: begin
							c = lsb;
							v = (v >> 1) | (c ? top : 16'd0);
							o = ((v & top) != 0) ^ ((v & sub) != 0);
						end
						CMD_RCL: begin
							v = ((v << 1) | c) & mask;
							c = msb;
							o = v[pos] ^ c;
						end
						CMD_RCR: begin
							v = (v >> 1) | (c ? top : 16'd0);
							c = lsb;
							o = ((v & top) != 0) ^ ((v & sub) != 0);
						end
						CMD_SHL: begin
							c = msb;
							v = (v << 1) & mask;
							o = v[pos] ^ c;
						end
						CMD_SHR: begin
							o = msb;
							c = lsb;
							v = v >> 1;
						end
						default: begin
							c = lsb;
							v = (v >> 1) | (v & top);
							o = 1'b0;
						end
					endcase
				end
				kept_flags.c = c;
				kept_flags.o = o;
				// Rotates leave zero and sign alone.
				if (cmd >= CMD_SHL) begin
					kept_flags.z = (v == 16'd0);
					kept_flags.s = ((v & top) != 0);
				end
			end
			res.result_value = v;
		end else if (cmd <= CMD_TEST) begin
			case (cmd)
				CMD_AND: v = v & s;
				CMD_OR:  v = v | s;
				CMD_XOR: v = v ^ s;
				default: begin
					v = v & s;
					res.write_back = 1'b0;
				end
			endcase
			v = v & mask;
			kept_flags.c = 1'b0;
			kept_flags.o = 1'b0;
			kept_flags.z = (v == 16'd0);
			kept_flags.s = ((v & top) != 0);
			res.result_value = v;
		end else begin
			res.result_value = v;
			res.write_back = 1'b0;
		end
		res.flags = kept_flags;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		if (mismatches < 200)
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	// Receiver: random stalls, or a solid hold-off while one is running.
	always @(posedge clk) begin
		if (!arst_n || hold_off_active) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Result checker: every accepted result word against the oldest pending one.
	always @(posedge clk) begin : check_results
		alu_word_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", rsp.result_value, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp.result_value !== want.result_value)
					report_mismatch("result_value", rsp.result_value, want.result_value);
				if (rsp.write_back !== want.write_back)
					report_mismatch("write_back", rsp.write_back, want.write_back);
				if (rsp.carry_out !== want.flags.c)
					report_mismatch("carry_out", rsp.carry_out, want.flags.c);
				if (rsp.overflow_out !== want.flags.o)
					report_mismatch("overflow_out", rsp.overflow_out, want.flags.o);
				if (rsp.zero_out !== want.flags.z)
					report_mismatch("zero_out", rsp.zero_out, want.flags.z);
				if (rsp.sign_out !== want.flags.s)
					report_mismatch("sign_out", rsp.sign_out, want.flags.s);
			end
		end
	end

	// Offer one word, with a random idle gap first; returns at the accepting edge.
	// The prediction is taken at acceptance so the flag state follows input order.
	task automatic send_word(input logic [3:0] cmd, input logic wide, input logic [15:0] dest,
		input logic [15:0] src, input logic [7:0] count);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.command      <= cmd;
		req.word_size    <= wide;
		req.dest_value   <= dest;
		req.source_value <= src;
		req.shift_count  <= count;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending_results.push_back(compute_alu_word(cmd, wide, dest, src, count));
	endtask

	// Operands lean toward the values where flags turn over.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'h0080;
			5: return 16'h007F;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// Counts: mostly small, with zero and one common, occasional full range.
	function automatic logic [7:0] pick_count();
		int unsigned r;
		r = $urandom_range(19);
		if (r < 2)
			return 8'd0;
		else if (r < 5)
			return 8'd1;
		else if (r < 15)
			return 8'($urandom_range(17, 2));
		else
			return 8'($urandom_range(255));
	endfunction

	function automatic logic [3:0] pick_command();
		if ($urandom_range(99) < 4)
			return 4'($urandom_range(CMD_CODE_MAX, CMD_UNUSED_LO));
		return 4'($urandom_range(CMD_TEST));
	endfunction

	task automatic wait_for_drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Directed corners: size extremes, count extremes, flag keep/clear rules.
	task automatic test_corner_cases();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_word(CMD_OR,   1'b1, 16'h0000, 16'h0000, 8'd0);   // zero flag set
		send_word(CMD_ROL,  1'b1, 16'h8001, 16'h0000, 8'd0);   // zero count keeps flags
		send_word(CMD_ROL,  1'b0, 16'hFF81, 16'h0000, 8'd1);   // rotate keeps zero/sign
		send_word(CMD_ROR,  1'b1, 16'h0001, 16'h0000, 8'd1);
		send_word(CMD_RCL,  1'b0, 16'h00FF, 16'h0000, 8'd9);   // full trip through carry
		send_word(CMD_RCR,  1'b1, 16'hFFFF, 16'h0000, 8'd17);
		send_word(CMD_RCL,  1'b1, 16'h8000, 16'h0000, 8'd1);
		send_word(CMD_SHL,  1'b1, 16'hFFFF, 16'h0000, 8'd255); // count is not masked
		send_word(CMD_SHR,  1'b0, 16'h0080, 16'h0000, 8'd8);
		send_word(CMD_SHR,  1'b1, 16'hFFFF, 16'h0000, 8'd16);
		send_word(CMD_SAR,  1'b1, 16'h8000, 16'h0000, 8'd255);
		send_word(CMD_SAR,  1'b0, 16'h007F, 16'h0000, 8'd3);
		send_word(CMD_SHL,  1'b0, 16'h0040, 16'h0000, 8'd1);   // byte overflow position
		send_word(CMD_ROR,  1'b0, 16'h00FE, 16'h0000, 8'd255);
		send_word(CMD_AND,  1'b1, 16'hFFFF, 16'hFFFF, 8'd0);   // logic clears carry/overflow
		send_word(CMD_OR,   1'b0, 16'h0000, 16'h0080, 8'd7);
		send_word(CMD_XOR,  1'b1, 16'hAAAA, 16'h5555, 8'd0);
		send_word(CMD_XOR,  1'b0, 16'hFF12, 16'hAB34, 8'd0);   // upper bytes ignored
		send_word(CMD_TEST, 1'b1, 16'h8000, 16'h8000, 8'd0);   // no write-back
		send_word(CMD_UNUSED_LO, 1'b0, 16'h1234, 16'hFFFF, 8'd255);
		send_word(CMD_CODE_MAX,  1'b1, 16'hFFFF, 16'hFFFF, 8'd1);
	endtask

	// Random mix under one idle setting.
	task automatic test_random_traffic(input int unsigned words, input int unsigned idle_pct,
		input int unsigned stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (words)
			send_word(pick_command(), 1'($urandom_range(1)), pick_operand(), pick_operand(),
				pick_count());
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering;
	// the two stages fill and the input side must stall.
	task automatic test_long_stall();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		->hold_off_start;
		repeat (40)
			send_word(pick_command(), 1'($urandom_range(1)), pick_operand(), pick_operand(),
				pick_count());
	endtask

	initial begin
		req.valid        <= 1'b0;
		req.command      <= CMD_ROL;
		req.word_size    <= 1'b0;
		req.dest_value   <= 16'h0000;
		req.source_value <= 16'h0000;
		req.shift_count  <= 8'd0;
		arst_n           <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_traffic(420, 0, 0);
		test_random_traffic(420, 46, 0);
		test_random_traffic(420, 0, 46);
		test_random_traffic(350, 8, 8);
		test_long_stall();
		test_random_traffic(50, 46, 46);

		req.valid <= 1'b0;
		wait_for_drain();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
